/* rtl/core/tpsa_pkg.sv */
// ----------------------------------------------------------------------------
// tpsa_pkg
// Shared types and codes for the two-pool slab slot allocator.
// ----------------------------------------------------------------------------
package tpsa_pkg;

    // Pool grant index width: 4 bits can number up to 16 slots.
    localparam int SLOT_IDX_W = 4;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [3:0] {
        STAT_RX_GRANT  = 4'd0,
        STAT_TX_GRANT  = 4'd1,
        STAT_RX_EXH    = 4'd2,
        STAT_TX_EXH    = 4'd3,
        STAT_HEAP      = 4'd4,
        STAT_ZERO      = 4'd5,
        STAT_FREED     = 4'd6,
        STAT_HEAP_FREE = 4'd7,
        STAT_NULL      = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        TGT_NULL = 2'd0,
        TGT_RX   = 2'd1,
        TGT_TX   = 2'd2,
        TGT_HEAP = 2'd3
    } target_t;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_IN_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN  = 2'd2;

    localparam logic [15:0] IN_LEN_RST  = 16'd16384;
    localparam logic [15:0] OUT_LEN_RST = 16'd8192;
    localparam logic [11:0] MARGIN_RST  = 12'd256;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHK_RX,
        ST_CHK_TX,
        ST_RESP
    } state_t;

    // Control into one slot pool.
    typedef struct packed {
        logic       take;
        logic       release_en;
        logic [1:0] release_idx;
    } pool_ctrl_t;

    // Status out of one slot pool.
    typedef struct packed {
        logic                  avail;
        logic [SLOT_IDX_W-1:0] grant_idx;
    } pool_stat_t;

endpackage

/* rtl/core/two_pool_slab_slot_allocator.sv */
// ----------------------------------------------------------------------------
// two_pool_slab_slot_allocator
// Slab slot allocator for a receive and a transmit pool with heap fallback.
// ----------------------------------------------------------------------------
//
//  channel   | dir | ports                          | handshake
//  ----------+-----+--------------------------------+------------------------
//  request   | in  | s_func .. s_free_slot          | s_valid / s_ready
//  result    | out | m_status .. m_heap_count       | m_valid / m_ready
//  config    | in  | cfg_index, cfg_wdata           | cfg_wen, no wait
//
//  Allocate beats go from accept to result load through the multiply, rx
//  window check, tx window check and respond steps; an rx window hit skips
//  the tx check. Free beats go straight to the respond step. The sequencer is
//  back in idle after the load, and only there accepts the next beat. The
//  single window compare unit is reused for both pools.
//  Reset (aresetn, synchronous, active low) frees every slot, zeroes the
//  counters and loads the default config.
//  s_ready is high only in idle. The result register frees the sequencer:
//  a new beat is accepted while the last result still waits on m_ready; the
//  respond step stalls only if the result register is still full.
// ----------------------------------------------------------------------------
module two_pool_slab_slot_allocator #(
    parameter int SLOT_COUNT = 3
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [15:0] s_elem_count,
    input  logic [15:0] s_elem_size,
    input  logic [1:0]  s_free_target,
    input  logic [1:0]  s_free_slot,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_status,
    output logic [1:0]  m_slot_index,
    output logic [31:0] m_clear_len,
    output logic [31:0] m_rx_hit_count,
    output logic [31:0] m_tx_hit_count,
    output logic [31:0] m_rx_exhausted_count,
    output logic [31:0] m_tx_exhausted_count,
    output logic [31:0] m_heap_count
);

    // Config registers
    logic [15:0] in_len_reg;
    logic [15:0] out_len_reg;
    logic [11:0] margin_reg;

    // Sequencer
    tpsa_pkg::state_t state_reg;
    tpsa_pkg::state_t state_next;

    // Captured request
    logic        func_reg;
    logic [15:0] count_reg;
    logic [15:0] esize_reg;
    logic [1:0]  target_reg;
    logic [1:0]  fslot_reg;

    // Working values
    logic [31:0] size_reg;
    logic        rx_match_reg;
    logic        tx_match_reg;

    // Running counters
    logic [31:0] rx_hits_reg,  rx_hits_next;
    logic [31:0] tx_hits_reg,  tx_hits_next;
    logic [31:0] rx_exh_reg,   rx_exh_next;
    logic [31:0] tx_exh_reg,   tx_exh_next;
    logic [31:0] heap_reg,     heap_next;

    // Result register
    logic        m_valid_reg;
    logic [3:0]  status_reg;
    logic [1:0]  slot_reg;
    logic [31:0] clear_reg;

    // Shared window compare
    logic [15:0] cmp_len;
    logic        cmp_hit;

    // Pools
    tpsa_pkg::pool_ctrl_t rx_ctrl, tx_ctrl;
    tpsa_pkg::pool_stat_t rx_stat, tx_stat;

    // Respond-step decision
    logic                     accept;
    logic                     resp_fire;
    tpsa_pkg::status_t        status_next;
    logic [1:0]               slot_next;
    logic [31:0]              clear_next;
    logic                     fslot_ok;

    assign accept = s_valid && s_ready;

    // ------------------------------------------------------------------
    // Config writes: unknown indexes fall through and are dropped.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_len_reg  <= tpsa_pkg::IN_LEN_RST;
            out_len_reg <= tpsa_pkg::OUT_LEN_RST;
            margin_reg  <= tpsa_pkg::MARGIN_RST;
        end else if (cfg_wen) begin
            priority case (cfg_index)
                tpsa_pkg::CFG_IN_LEN:  in_len_reg  <= cfg_wdata;
                tpsa_pkg::CFG_OUT_LEN: out_len_reg <= cfg_wdata;
                tpsa_pkg::CFG_MARGIN:  margin_reg  <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // One compare unit, pointed at rx or tx length by the sequencer.
    // ------------------------------------------------------------------
    assign cmp_len = (state_reg == tpsa_pkg::ST_CHK_TX) ? out_len_reg : in_len_reg;

    tpsa_match u_match (
        .size   (size_reg),
        .len    (cmp_len),
        .margin (margin_reg),
        .hit    (cmp_hit)
    );

    tpsa_slot_pool #(.SLOT_COUNT(SLOT_COUNT)) u_rx_pool (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (rx_ctrl),
        .stat    (rx_stat)
    );

    tpsa_slot_pool #(.SLOT_COUNT(SLOT_COUNT)) u_tx_pool (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (tx_ctrl),
        .stat    (tx_stat)
    );

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tpsa_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = (s_func == tpsa_pkg::FUNC_FREE) ? tpsa_pkg::ST_RESP
                                                                 : tpsa_pkg::ST_MUL;
                end
            end
            tpsa_pkg::ST_MUL:    state_next = tpsa_pkg::ST_CHK_RX;
            // rx wins when both windows match, so a hit skips the tx check
            tpsa_pkg::ST_CHK_RX: state_next = cmp_hit ? tpsa_pkg::ST_RESP
                                                      : tpsa_pkg::ST_CHK_TX;
            tpsa_pkg::ST_CHK_TX: state_next = tpsa_pkg::ST_RESP;
            tpsa_pkg::ST_RESP: begin
                if (resp_fire) begin
                    state_next = tpsa_pkg::ST_IDLE;
                end
            end
            default: state_next = tpsa_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs and respond decision
    // ------------------------------------------------------------------
    assign fslot_ok = ({3'd0, fslot_reg} < 5'(SLOT_COUNT));

    always_comb begin
        s_ready      = (state_reg == tpsa_pkg::ST_IDLE);
        resp_fire    = (state_reg == tpsa_pkg::ST_RESP) && (!m_valid_reg || m_ready);
        status_next  = tpsa_pkg::STAT_NULL;
        slot_next    = 2'd0;
        clear_next   = 32'd0;
        rx_ctrl      = '0;
        tx_ctrl      = '0;
        rx_hits_next = rx_hits_reg;
        tx_hits_next = tx_hits_reg;
        rx_exh_next  = rx_exh_reg;
        tx_exh_next  = tx_exh_reg;
        heap_next    = heap_reg;

        if (func_reg == tpsa_pkg::FUNC_ALLOC) begin
            priority if (size_reg == 32'd0) begin
                status_next = tpsa_pkg::STAT_ZERO;
            end else if (rx_match_reg) begin
                if (rx_stat.avail) begin
                    status_next  = tpsa_pkg::STAT_RX_GRANT;
                    slot_next    = rx_stat.grant_idx[1:0];
                    clear_next   = size_reg;
                    rx_ctrl.take = resp_fire;
                    rx_hits_next = rx_hits_reg + 32'd1;
                end else begin
                    status_next = tpsa_pkg::STAT_RX_EXH;
                    rx_exh_next = rx_exh_reg + 32'd1;
                end
            end else if (tx_match_reg) begin
                if (tx_stat.avail) begin
                    status_next  = tpsa_pkg::STAT_TX_GRANT;
                    slot_next    = tx_stat.grant_idx[1:0];
                    clear_next   = size_reg;
                    tx_ctrl.take = resp_fire;
                    tx_hits_next = tx_hits_reg + 32'd1;
                end else begin
                    status_next = tpsa_pkg::STAT_TX_EXH;
                    tx_exh_next = tx_exh_reg + 32'd1;
                end
            end else begin
                status_next = tpsa_pkg::STAT_HEAP;
                clear_next  = size_reg;
                heap_next   = heap_reg + 32'd1;
            end
        end else begin
            priority if (target_reg == tpsa_pkg::TGT_NULL) begin
                status_next = tpsa_pkg::STAT_NULL;
            end else if (target_reg == tpsa_pkg::TGT_HEAP || !fslot_ok) begin
                // slot number past the pool is treated as a heap block
                status_next = tpsa_pkg::STAT_HEAP_FREE;
            end else begin
                status_next = tpsa_pkg::STAT_FREED;
                if (target_reg == tpsa_pkg::TGT_RX) begin
                    rx_ctrl.release_en  = resp_fire;
                    rx_ctrl.release_idx = fslot_reg;
                end else begin
                    tx_ctrl.release_en  = resp_fire;
                    tx_ctrl.release_idx = fslot_reg;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            func_reg   <= s_func;
            count_reg  <= s_elem_count;
            esize_reg  <= s_elem_size;
            target_reg <= s_free_target;
            fslot_reg  <= s_free_slot;
        end
        // 16x16 always fits in 32 bits, so no saturation is needed
        if (state_reg == tpsa_pkg::ST_MUL) begin
            size_reg <= 32'(count_reg) * 32'(esize_reg);
        end
        if (state_reg == tpsa_pkg::ST_CHK_RX) begin
            rx_match_reg <= cmp_hit;
            tx_match_reg <= 1'b0;
        end
        if (state_reg == tpsa_pkg::ST_CHK_TX) begin
            tx_match_reg <= cmp_hit;
        end
        if (resp_fire) begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            clear_reg  <= clear_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tpsa_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            rx_hits_reg <= '0;
            tx_hits_reg <= '0;
            rx_exh_reg  <= '0;
            tx_exh_reg  <= '0;
            heap_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (resp_fire) begin
                m_valid_reg <= 1'b1;
                rx_hits_reg <= rx_hits_next;
                tx_hits_reg <= tx_hits_next;
                rx_exh_reg  <= rx_exh_next;
                tx_exh_reg  <= tx_exh_next;
                heap_reg    <= heap_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Counter fields always show the post-update values, which the counter
    // registers hold until the next respond step.
    assign m_valid              = m_valid_reg;
    assign m_status             = status_reg;
    assign m_slot_index         = slot_reg;
    assign m_clear_len          = clear_reg;
    assign m_rx_hit_count       = rx_hits_reg;
    assign m_tx_hit_count       = tx_hits_reg;
    assign m_rx_exhausted_count = rx_exh_reg;
    assign m_tx_exhausted_count = tx_exh_reg;
    assign m_heap_count         = heap_reg;

endmodule

/* rtl/core/tpsa_match.sv */
// ----------------------------------------------------------------------------
// tpsa_match
// Shared window compare: len < size <= len + margin.
// ----------------------------------------------------------------------------
module tpsa_match (
    input  logic [31:0] size,
    input  logic [15:0] len,
    input  logic [11:0] margin,
    output logic        hit
);

    logic [32:0] diff;

    // diff = size - len - 1; no borrow means size > len, and then
    // size <= len + margin is the same as diff < margin.
    assign diff = {1'b0, size} - {17'd0, len} - 33'd1;
    assign hit  = !diff[32] && (diff[31:0] < {20'd0, margin});

endmodule

/* rtl/core/tpsa_slot_pool.sv */
// ----------------------------------------------------------------------------
// tpsa_slot_pool
// Busy bits of one slot pool with a lowest-free-slot finder.
// ----------------------------------------------------------------------------
module tpsa_slot_pool #(
    parameter int SLOT_COUNT = 3
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tpsa_pkg::pool_ctrl_t ctrl,
    output tpsa_pkg::pool_stat_t stat
);

    logic [SLOT_COUNT-1:0] busy_reg;
    logic [SLOT_COUNT-1:0] busy_next;

    always_comb begin
        stat.avail     = 1'b0;
        stat.grant_idx = '0;
        // walk down so the lowest free slot wins
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                stat.avail     = 1'b1;
                stat.grant_idx = tpsa_pkg::SLOT_IDX_W'(i);
            end
        end
    end

    always_comb begin
        busy_next = busy_reg;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (ctrl.take && stat.avail && (stat.grant_idx == tpsa_pkg::SLOT_IDX_W'(i))) begin
                busy_next[i] = 1'b1;
            end
            if (ctrl.release_en && (int'(ctrl.release_idx) == i)) begin
                busy_next[i] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= '0;
        end else begin
            busy_reg <= busy_next;
        end
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-pool slab slot allocator. A directed table
// covers the window edges, exhaustion, frees and size extremes. Random
// request streams then run under several window settings. Every result beat
// is checked field by field against an allocator model kept in the bench.
// ----------------------------------------------------------------------------
module testbench;
    import tpsa_pkg::*;

    localparam int SLOTS          = 3;
    localparam int IDLE_LIMIT     = 2000;   // cycles with no beat on either side
    localparam int RAND_PER_PHASE = 185;
    localparam int PHASES         = 6;
    // index with no register behind it; the block must drop such a write
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic        func;
        logic [15:0] count;
        logic [15:0] esize;
        target_t     tgt;
        logic [1:0]  fslot;
    } req_t;

    typedef struct packed {
        status_t     status;
        logic [1:0]  slot;
        logic [31:0] clear;
        logic [31:0] rx_hits;
        logic [31:0] tx_hits;
        logic [31:0] rx_exh;
        logic [31:0] tx_exh;
        logic [31:0] heap;
    } rsp_t;

    // One line of the directed table. With typed set, status, slot and clear
    // come from the row; counters always come from the allocator model.
    typedef struct packed {
        req_t        req;
        logic        typed;
        status_t     status;
        logic [1:0]  slot;
        logic [31:0] clear;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wen;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic        s_func;
    logic [15:0] s_elem_count;
    logic [15:0] s_elem_size;
    logic [1:0]  s_free_target;
    logic [1:0]  s_free_slot;
    logic        m_valid;
    logic        m_ready;
    logic [3:0]  m_status;
    logic [1:0]  m_slot_index;
    logic [31:0] m_clear_len;
    logic [31:0] m_rx_hit_count;
    logic [31:0] m_tx_hit_count;
    logic [31:0] m_rx_exhausted_count;
    logic [31:0] m_tx_exhausted_count;
    logic [31:0] m_heap_count;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    two_pool_slab_slot_allocator #(
        .SLOT_COUNT(SLOTS)
    ) dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wen              (cfg_wen),
        .cfg_index            (cfg_index),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_func               (s_func),
        .s_elem_count         (s_elem_count),
        .s_elem_size          (s_elem_size),
        .s_free_target        (s_free_target),
        .s_free_slot          (s_free_slot),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_status             (m_status),
        .m_slot_index         (m_slot_index),
        .m_clear_len          (m_clear_len),
        .m_rx_hit_count       (m_rx_hit_count),
        .m_tx_hit_count       (m_tx_hit_count),
        .m_rx_exhausted_count (m_rx_exhausted_count),
        .m_tx_exhausted_count (m_tx_exhausted_count),
        .m_heap_count         (m_heap_count)
    );

    // ------------------------------------------------------------------------
    // Allocator model: window registers, slot used bits, running counters
    // ------------------------------------------------------------------------
    logic [15:0] rx_len;
    logic [15:0] tx_len;
    logic [11:0] margin_bytes;
    logic        rx_busy [SLOTS];
    logic        tx_busy [SLOTS];
    logic [31:0] n_rx_hit, n_tx_hit, n_rx_exh, n_tx_exh, n_heap;

    rsp_t     expected_beats [$];
    dir_row_t corner_rows [$];
    int       errors = 0;
    bit       no_idle = 1'b0;   // both sides run back to back while set
    int       idle_cycles = 0;

    function automatic void model_reset();
        rx_len       = IN_LEN_RST;
        tx_len       = OUT_LEN_RST;
        margin_bytes = MARGIN_RST;
        for (int i = 0; i < SLOTS; i++) begin
            rx_busy[i] = 1'b0;
            tx_busy[i] = 1'b0;
        end
        n_rx_hit = '0;
        n_tx_hit = '0;
        n_rx_exh = '0;
        n_tx_exh = '0;
        n_heap   = '0;
    endfunction

    // pool takes len < bytes <= len + margin; margin is at most 4095 so the
    // upper bound never leaves 32 bits
    function automatic bit in_window(logic [31:0] bytes, logic [15:0] len);
        return bytes > 32'(len) && bytes <= 32'(len) + 32'(margin_bytes);
    endfunction

    function automatic rsp_t slab_predict(req_t r);
        rsp_t        o;
        logic [31:0] bytes;
        int          i;
        o = '0;
        // 16x16 product always fits 32 bits, so no saturation here
        bytes = 32'(r.count) * 32'(r.esize);
        if (r.func == FUNC_ALLOC) begin
            if (bytes == 32'd0) begin
                o.status = STAT_ZERO;
            end else if (in_window(bytes, rx_len)) begin
                // rx is checked first, so it wins where the windows overlap
                o.status = STAT_RX_EXH;
                for (i = 0; i < SLOTS && o.status == STAT_RX_EXH; i++) begin
                    if (!rx_busy[i]) begin
                        rx_busy[i] = 1'b1;
                        o.status   = STAT_RX_GRANT;
                        o.slot     = 2'(i);
                        o.clear    = bytes;
                    end
                end
                if (o.status == STAT_RX_GRANT) n_rx_hit++;
                else n_rx_exh++;
            end else if (in_window(bytes, tx_len)) begin
                o.status = STAT_TX_EXH;
                for (i = 0; i < SLOTS && o.status == STAT_TX_EXH; i++) begin
                    if (!tx_busy[i]) begin
                        tx_busy[i] = 1'b1;
                        o.status   = STAT_TX_GRANT;
                        o.slot     = 2'(i);
                        o.clear    = bytes;
                    end
                end
                if (o.status == STAT_TX_GRANT) n_tx_hit++;
                else n_tx_exh++;
            end else begin
                o.status = STAT_HEAP;
                o.clear  = bytes;
                n_heap++;
            end
        end else begin
            case (r.tgt)
                TGT_NULL: o.status = STAT_NULL;
                TGT_HEAP: o.status = STAT_HEAP_FREE;
                default: begin
                    // slot number past the pool falls through to a heap free
                    if (int'(r.fslot) >= SLOTS) begin
                        o.status = STAT_HEAP_FREE;
                    end else begin
                        if (r.tgt == TGT_RX) rx_busy[r.fslot] = 1'b0;
                        else tx_busy[r.fslot] = 1'b0;
                        o.status = STAT_FREED;
                    end
                end
            endcase
        end
        o.rx_hits = n_rx_hit;
        o.tx_hits = n_tx_hit;
        o.rx_exh  = n_rx_exh;
        o.tx_exh  = n_tx_exh;
        o.heap    = n_heap;
        return o;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic dir_row_t dir_row(logic func, logic [15:0] cnt, logic [15:0] sz,
                                         target_t t, logic [1:0] fs, logic typed,
                                         status_t st, logic [1:0] sl, logic [31:0] cl);
        dir_row_t d;
        d.req    = '{func: func, count: cnt, esize: sz, tgt: t, fslot: fs};
        d.typed  = typed;
        d.status = st;
        d.slot   = sl;
        d.clear  = cl;
        return d;
    endfunction

    // Mostly sizes aimed into one of the pool windows; the rest zero sizes,
    // full-range sizes (heap traffic) and frees of every kind.
    function automatic req_t random_request();
        req_t        r;
        int          pick, c, lo, hi;
        logic [15:0] len;
        r.func  = FUNC_ALLOC;
        r.count = 16'($urandom);
        r.esize = 16'($urandom);
        r.tgt   = target_t'($urandom_range(0, 3));
        r.fslot = 2'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            len = (pick < 35) ? rx_len : tx_len;
            c   = $urandom_range(1, 4);
            lo  = (int'(len) + c) / c;              // smallest size with c*s > len
            hi  = (int'(len) + int'(margin_bytes)) / c;
            if (hi > 65535) hi = 65535;
            // empty window: leave the full-range sizes in place
            if (lo <= hi) begin
                r.count = 16'(c);
                r.esize = 16'($urandom_range(hi, lo));
            end
        end else if (pick < 60) begin
            if ($urandom_range(0, 1) == 0) r.count = '0;
            else r.esize = '0;
        end else if (pick >= 70) begin
            r.func = FUNC_FREE;
            if ($urandom_range(0, 4) != 0)
                r.tgt = ($urandom_range(0, 1) == 0) ? TGT_RX : TGT_TX;
        end
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the accept.
    task automatic push_request(req_t r, logic typed, status_t st, logic [1:0] sl,
                                logic [31:0] cl);
        int   gap;
        rsp_t want;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= r.func;
        s_elem_count  <= r.count;
        s_elem_size   <= r.esize;
        s_free_target <= r.tgt;
        s_free_slot   <= r.fslot;
        do @(posedge aclk); while (!s_ready);
        want = slab_predict(r);
        if (typed) begin
            want.status = st;
            want.slot   = sl;
            want.clear  = cl;
        end
        expected_beats.push_back(want);
        @(negedge aclk);
    endtask

    // Lower valid and wait for every outstanding result beat.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_beats.size() != 0) @(negedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wen <= 1'b0;
        case (idx)
            CFG_IN_LEN:  rx_len       = data;
            CFG_OUT_LEN: tx_len       = data;
            CFG_MARGIN:  margin_bytes = data[11:0];
            default: ;
        endcase
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s mismatch: got 0x%0h, want 0x%0h", $time, what, got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls on m_ready, one draw per result beat
    // ------------------------------------------------------------------------
    initial begin
        int stall;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    // Checker: each result beat against the oldest expectation.
    always @(posedge aclk) begin
        rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                report_mismatch("unexpected result beat, status", 32'(m_status), '0);
            end else begin
                want = expected_beats.pop_front();
                if (m_status !== want.status)
                    report_mismatch("status", 32'(m_status), 32'(want.status));
                if (m_slot_index !== want.slot)
                    report_mismatch("slot_index", 32'(m_slot_index), 32'(want.slot));
                if (m_clear_len !== want.clear)
                    report_mismatch("clear_len", m_clear_len, want.clear);
                if (m_rx_hit_count !== want.rx_hits)
                    report_mismatch("rx_hit_count", m_rx_hit_count, want.rx_hits);
                if (m_tx_hit_count !== want.tx_hits)
                    report_mismatch("tx_hit_count", m_tx_hit_count, want.tx_hits);
                if (m_rx_exhausted_count !== want.rx_exh)
                    report_mismatch("rx_exhausted_count", m_rx_exhausted_count,
                                    want.rx_exh);
                if (m_tx_exhausted_count !== want.tx_exh)
                    report_mismatch("tx_exhausted_count", m_tx_exhausted_count,
                                    want.tx_exh);
                if (m_heap_count !== want.heap)
                    report_mismatch("heap_count", m_heap_count, want.heap);
            end
        end
    end

    // Watchdog: too long with no beat on either channel means a hang.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn       = 1'b0;
        cfg_wen       = 1'b0;
        cfg_index     = CFG_IN_LEN;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_func        = FUNC_ALLOC;
        s_elem_count  = '0;
        s_elem_size   = '0;
        s_free_target = TGT_NULL;
        s_free_slot   = '0;
        model_reset();

        // Reset windows: rx 16385..16640, tx 8193..8448.
        //                                 func        count     size      tgt       fs
        corner_rows.push_back(dir_row(FUNC_ALLOC, 16'd0,     16'd7,     TGT_HEAP, 2'd3,
                                      1, STAT_ZERO,      2'd0, 32'd0));
        corner_rows.push_back(dir_row(FUNC_ALLOC, 16'hFFFF,  16'd0,     TGT_RX,   2'd2,
                                      1, STAT_ZERO,      2'd0, 32'd0));
        // largest product, straight to the heap
        corner_rows.push_back(dir_row(FUNC_ALLOC, 16'hFFFF,  16'hFFFF,  TGT_TX,   2'd1,
                                      1, STAT_HEAP,      2'd0, 32'hFFFE_0001));
        // just above rx content length
        corner_rows.push_back(dir_row(FUNC_ALLOC, 16'd1,     16'd16385, TGT_NULL, 2'd0,
                                      1, STAT_RX_GRANT,  2'd0, 32'd16385));
        // exactly the content length misses the window
        corner_rows.push_back(dir_row(FUNC_ALLOC, 16'd1,     16'd16384, TGT_NULL, 2'd0,
                                      1, STAT_HEAP,      2'd0, 32'd16384));
        // top of the rx window
        corner_rows.push_back(dir_row(FUNC_ALLOC, 16'd2,     16'd8320,  TGT_NULL, 2'd0,
                                      1, STAT_RX_GRANT,  2'd1, 32'd16640));
        corner_rows.push_back(dir_row(FUNC_ALLOC, 16'd1,     16'd16641, TGT_NULL, 2'd0,
                                      1, STAT_HEAP,      2'd0, 32'd16641));
        corner_rows.push_back(dir_row(FUNC_ALLOC, 16'd4,     16'd4125,  TGT_NULL, 2'd0,
                                      1, STAT_RX_GRANT,  2'd2, 32'd16500));
        // rx pool full
        corner_rows.push_back(dir_row(FUNC_ALLOC, 16'd1,     16'd16400, TGT_NULL, 2'd0,
                                      1, STAT_RX_EXH,    2'd0, 32'd0));
        corner_rows.push_back(dir_row(FUNC_ALLOC, 16'd1,     16'd8193,  TGT_NULL, 2'd0,
                                      1, STAT_TX_GRANT,  2'd0, 32'd8193));
        corner_rows.push_back(dir_row(FUNC_ALLOC, 16'd1,     16'd8448,  TGT_NULL, 2'd0,
                                      1, STAT_TX_GRANT,  2'd1, 32'd8448));
        corner_rows.push_back(dir_row(FUNC_ALLOC, 16'd1,     16'd8192,  TGT_NULL, 2'd0,
                                      1, STAT_HEAP,      2'd0, 32'd8192));
        corner_rows.push_back(dir_row(FUNC_ALLOC, 16'd8,     16'd1030,  TGT_NULL, 2'd0,
                                      1, STAT_TX_GRANT,  2'd2, 32'd8240));
        // tx pool full
        corner_rows.push_back(dir_row(FUNC_ALLOC, 16'd1,     16'd8200,  TGT_NULL, 2'd0,
                                      1, STAT_TX_EXH,    2'd0, 32'd0));
        corner_rows.push_back(dir_row(FUNC_FREE,  16'hFFFF,  16'hFFFF,  TGT_NULL, 2'd1,
                                      1, STAT_NULL,      2'd0, 32'd0));
        corner_rows.push_back(dir_row(FUNC_FREE,  16'd0,     16'd0,     TGT_HEAP, 2'd0,
                                      1, STAT_HEAP_FREE, 2'd0, 32'd0));
        // slot number past the pool becomes a heap free
        corner_rows.push_back(dir_row(FUNC_FREE,  16'd0,     16'd0,     TGT_RX,   2'd3,
                                      1, STAT_HEAP_FREE, 2'd0, 32'd0));
        corner_rows.push_back(dir_row(FUNC_FREE,  16'd0,     16'd0,     TGT_TX,   2'd3,
                                      1, STAT_HEAP_FREE, 2'd0, 32'd0));
        corner_rows.push_back(dir_row(FUNC_FREE,  16'd0,     16'd0,     TGT_RX,   2'd1,
                                      1, STAT_FREED,     2'd0, 32'd0));
        // second free of the same slot
        corner_rows.push_back(dir_row(FUNC_FREE,  16'd0,     16'd0,     TGT_RX,   2'd1,
                                      1, STAT_FREED,     2'd0, 32'd0));
        corner_rows.push_back(dir_row(FUNC_ALLOC, 16'd1,     16'd16385, TGT_NULL, 2'd0,
                                      1, STAT_RX_GRANT,  2'd1, 32'd16385));
        corner_rows.push_back(dir_row(FUNC_FREE,  16'd0,     16'd0,     TGT_TX,   2'd2,
                                      1, STAT_FREED,     2'd0, 32'd0));
        corner_rows.push_back(dir_row(FUNC_ALLOC, 16'd3,     16'd2800,  TGT_NULL, 2'd0,
                                      1, STAT_TX_GRANT,  2'd2, 32'd8400));
        corner_rows.push_back(dir_row(FUNC_FREE,  16'd0,     16'd0,     TGT_RX,   2'd0,
                                      0, STAT_FREED,     2'd0, 32'd0));
        corner_rows.push_back(dir_row(FUNC_ALLOC, 16'h8000,  16'd2,     TGT_NULL, 2'd0,
                                      0, STAT_HEAP,      2'd0, 32'd0));

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (corner_rows[i])
            push_request(corner_rows[i].req, corner_rows[i].typed, corner_rows[i].status,
                         corner_rows[i].slot, corner_rows[i].clear);
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            // block is idle here: every result beat has been taken
            case (p)
                1: begin    // lowest lengths, no margin: both windows empty
                    write_reg(CFG_IN_LEN,  16'd1);
                    write_reg(CFG_OUT_LEN, 16'd1);
                    write_reg(CFG_MARGIN,  16'd0);
                end
                2: begin    // top lengths, identical windows; margin upper bits dropped
                    write_reg(CFG_IN_LEN,  16'hFFFF);
                    write_reg(CFG_OUT_LEN, 16'hFFFF);
                    write_reg(CFG_MARGIN,  16'hFFFF);
                end
                3: begin    // overlapping windows, rx takes the shared range
                    write_reg(CFG_IN_LEN,  16'd1000);
                    write_reg(CFG_OUT_LEN, 16'd900);
                    write_reg(CFG_MARGIN,  16'd200);
                end
                4: begin
                    write_reg(CFG_SPARE,   16'($urandom));
                    write_reg(CFG_IN_LEN,  16'($urandom_range(1, 65535)));
                    write_reg(CFG_OUT_LEN, 16'($urandom_range(1, 65535)));
                    write_reg(CFG_MARGIN,  16'($urandom_range(0, 4095)));
                end
                5: begin    // short lengths so small products reach the pools
                    write_reg(CFG_IN_LEN,  16'($urandom_range(1, 2000)));
                    write_reg(CFG_OUT_LEN, 16'($urandom_range(1, 2000)));
                    write_reg(CFG_MARGIN,  16'($urandom_range(0, 4095)));
                end
                default: ;
            endcase
            for (int k = 0; k < RAND_PER_PHASE; k++) begin
                if (k % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
                push_request(random_request(), 1'b0, STAT_ZERO, 2'd0, 32'd0);
            end
            no_idle = 1'b0;
            wait_drained();
        end

        // allow for a stray late beat
        repeat (20) @(posedge aclk);
        if (errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
